// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the frame decoder RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define XCFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define XCFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/xcfd_pkg.sv =====
// Package for the XOR checksum frame decoder: constants, codes and types.
// No dependencies.
package xcfd_pkg;

  localparam int MAX_PAYLOAD_DEF = 128;
  localparam int BYTE_W          = 8;
  localparam int HALF_W          = 16;
  localparam int EVT_W           = 2;
  localparam int IDX_W           = 7;
  localparam int PHASE_W         = 3;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFE;

  // receiver phases
  localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FN_HI  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FN_LO  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CHECK  = 3'd6;

  // result events
  localparam logic [EVT_W-1:0] EV_OK   = 2'd0;
  localparam logic [EVT_W-1:0] EV_BAD  = 2'd1;
  localparam logic [EVT_W-1:0] EV_READ = 2'd2;
  localparam logic [EVT_W-1:0] EV_LONG = 2'd3;

  // operations
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result held between parser and output stage
  typedef struct packed {
    logic [EVT_W-1:0]  evt;
    logic [HALF_W-1:0] fn;
    logic [HALF_W-1:0] len;
    logic              rd_hit;
  } res_t;

endpackage

// ===== hw/rtl/xcfd_ifs.sv =====
// Valid/ready channel interfaces for the frame decoder.
// Depends on xcfd_pkg for field widths.
interface xcfd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [xcfd_pkg::BYTE_W-1:0]  rx_byte;
  logic [xcfd_pkg::IDX_W-1:0]   read_index;

  modport source (output valid, operation, rx_byte, read_index, input ready);
  modport sink   (input valid, operation, rx_byte, read_index, output ready);
endinterface

interface xcfd_out_if;
  logic                         valid;
  logic                         ready;
  logic [xcfd_pkg::EVT_W-1:0]   event_res;
  logic [xcfd_pkg::HALF_W-1:0]  function_code;
  logic [xcfd_pkg::HALF_W-1:0]  payload_length;
  logic [xcfd_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, event_res, function_code, payload_length, data_byte,
                  input ready);
  modport sink   (input valid, event_res, function_code, payload_length, data_byte,
                  output ready);
endinterface

// ===== hw/rtl/xcfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module xcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/xcfd_parser.sv =====
// Frame parser: receive state machine, running checksum, payload store control
// and the first result register. Depends on xcfd_pkg, xcfd_ifs, assert_macros.svh.
`include "assert_macros.svh"

module xcfd_parser #(
  parameter int MAX_PAYLOAD = xcfd_pkg::MAX_PAYLOAD_DEF,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int PW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  xcfd_in_if.sink                     in_if,
  input  logic                        take,      // output stage can load
  output logic                        s1_valid,
  output xcfd_pkg::res_t              s1_res,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [xcfd_pkg::BYTE_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr
);

  logic [xcfd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [xcfd_pkg::HALF_W-1:0]  fn_r, fn_nxt;
  logic [xcfd_pkg::HALF_W-1:0]  len_r, len_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [xcfd_pkg::BYTE_W-1:0]  csum_r, csum_nxt;
  logic [PW-1:0]                acc_r, acc_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  xcfd_pkg::res_t               s1_r, s1_nxt;

  logic                         accept;
  logic [xcfd_pkg::BYTE_W-1:0]  b;
  logic [xcfd_pkg::HALF_W-1:0]  idx_ext;
  logic [xcfd_pkg::HALF_W-1:0]  len_new;
  logic [PW-1:0]                pos_inc;

  assign in_if.ready = take | ~s1_valid_r;
  assign accept      = in_if.valid & in_if.ready;
  assign b           = in_if.rx_byte;
  assign idx_ext     = {{(xcfd_pkg::HALF_W - xcfd_pkg::IDX_W){1'b0}}, in_if.read_index};
  assign len_new     = {len_r[15:8], b};
  assign pos_inc     = pos_r + PW'(1);

  // store port: writes in the payload phase, reads on a read operation
  assign wr_en   = accept & (in_if.operation == xcfd_pkg::OP_RX)
                   & (phase_r == xcfd_pkg::PH_DATA);
  assign wr_addr = pos_r[AW-1:0];
  assign wr_data = b;
  assign rd_en   = accept & (in_if.operation == xcfd_pkg::OP_READ);
  assign rd_addr = idx_ext[AW-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    fn_nxt       = fn_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    csum_nxt     = csum_r;
    acc_nxt      = acc_r;
    s1_valid_nxt = s1_valid_r & ~take;
    s1_nxt       = s1_r;

    if (accept) begin
      s1_valid_nxt = 1'b0;
      s1_nxt.fn     = fn_r;
      s1_nxt.len    = len_r;
      s1_nxt.evt    = xcfd_pkg::EV_READ;
      s1_nxt.rd_hit = 1'b0;
      if (in_if.operation == xcfd_pkg::OP_READ) begin
        s1_valid_nxt  = 1'b1;
        s1_nxt.evt    = xcfd_pkg::EV_READ;
        s1_nxt.fn     = '0;
        s1_nxt.len    = '0;
        s1_nxt.rd_hit = idx_ext < xcfd_pkg::HALF_W'(acc_r);
      end else begin
        unique case (phase_r)
          xcfd_pkg::PH_FN_HI: begin
            fn_nxt    = {b, 8'h00};
            csum_nxt  = csum_r ^ b;
            phase_nxt = xcfd_pkg::PH_FN_LO;
          end
          xcfd_pkg::PH_FN_LO: begin
            fn_nxt    = {fn_r[15:8], b};
            csum_nxt  = csum_r ^ b;
            phase_nxt = xcfd_pkg::PH_LEN_HI;
          end
          xcfd_pkg::PH_LEN_HI: begin
            len_nxt   = {b, 8'h00};
            csum_nxt  = csum_r ^ b;
            phase_nxt = xcfd_pkg::PH_LEN_LO;
          end
          xcfd_pkg::PH_LEN_LO: begin
            len_nxt  = len_new;
            csum_nxt = csum_r ^ b;
            pos_nxt  = '0;
            if (len_new == '0) begin
              phase_nxt = xcfd_pkg::PH_WAIT;      // empty frame, dropped
            end else if (len_new > xcfd_pkg::HALF_W'(MAX_PAYLOAD)) begin
              phase_nxt    = xcfd_pkg::PH_WAIT;   // too long, abandoned
              s1_valid_nxt = 1'b1;
              s1_nxt.evt   = xcfd_pkg::EV_LONG;
              s1_nxt.fn    = fn_r;
              s1_nxt.len   = len_new;
            end else begin
              acc_nxt   = '0;                     // store is about to be overwritten
              phase_nxt = xcfd_pkg::PH_DATA;
            end
          end
          xcfd_pkg::PH_DATA: begin
            csum_nxt = csum_r ^ b;
            pos_nxt  = pos_inc;
            if (xcfd_pkg::HALF_W'(pos_inc) >= len_r) begin
              phase_nxt = xcfd_pkg::PH_CHECK;
            end
          end
          xcfd_pkg::PH_CHECK: begin
            phase_nxt    = xcfd_pkg::PH_WAIT;
            s1_valid_nxt = 1'b1;
            s1_nxt.fn    = fn_r;
            s1_nxt.len   = len_r;
            if (csum_r == b) begin
              acc_nxt    = PW'(len_r);
              s1_nxt.evt = xcfd_pkg::EV_OK;
            end else begin
              s1_nxt.evt = xcfd_pkg::EV_BAD;
            end
          end
          default: begin
            phase_nxt = xcfd_pkg::PH_WAIT;
            if (b == xcfd_pkg::START_BYTE) begin
              fn_nxt    = '0;
              len_nxt   = '0;
              pos_nxt   = '0;
              csum_nxt  = xcfd_pkg::START_BYTE;
              phase_nxt = xcfd_pkg::PH_FN_HI;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= xcfd_pkg::PH_WAIT;
      fn_r       <= '0;
      len_r      <= '0;
      pos_r      <= '0;
      csum_r     <= xcfd_pkg::START_BYTE;
      acc_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      fn_r       <= fn_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      csum_r     <= csum_nxt;
      acc_r      <= acc_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_res   = s1_r;

  `XCFD_ASSERT(a_wr_in_data, wr_en |-> (phase_r == xcfd_pkg::PH_DATA), "store write outside payload phase")
  `XCFD_ASSERT(a_pos_in_frame, (phase_r == xcfd_pkg::PH_DATA) |-> (xcfd_pkg::HALF_W'(pos_r) < len_r), "payload position past frame length")
  `XCFD_ASSERT(a_acc_bound, xcfd_pkg::HALF_W'(acc_r) <= xcfd_pkg::HALF_W'(MAX_PAYLOAD), "accepted length exceeds store")
  `XCFD_ASSERT(a_no_load_while_full, (s1_valid_r && !take) |=> ($stable(s1_r) && s1_valid_r), "held result overwritten")

endmodule

// ===== hw/rtl/xcfd_out_stage.sv =====
// Output register: merges the held result with the payload store read data.
// Depends on xcfd_pkg, xcfd_ifs, assert_macros.svh.
`include "assert_macros.svh"

module xcfd_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  xcfd_pkg::res_t              s1_res,
  input  logic [xcfd_pkg::BYTE_W-1:0] rd_data,
  output logic                        take,
  xcfd_out_if.source                  out_if
);

  logic                        valid_r, valid_nxt;
  logic [xcfd_pkg::EVT_W-1:0]  evt_r;
  logic [xcfd_pkg::HALF_W-1:0] fn_r;
  logic [xcfd_pkg::HALF_W-1:0] len_r;
  logic [xcfd_pkg::BYTE_W-1:0] data_r;
  logic                        load;

  assign take      = ~valid_r | out_if.ready;
  assign load      = take & s1_valid;
  assign valid_nxt = take ? s1_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evt_r  <= s1_res.evt;
      fn_r   <= s1_res.fn;
      len_r  <= s1_res.len;
      data_r <= s1_res.rd_hit ? rd_data : '0;   // miss or non-read reads zero
    end
  end

  assign out_if.valid          = valid_r;
  assign out_if.event_res      = evt_r;
  assign out_if.function_code  = fn_r;
  assign out_if.payload_length = len_r;
  assign out_if.data_byte      = data_r;

  `XCFD_ASSERT(a_data_only_read, (valid_r && evt_r != xcfd_pkg::EV_READ) |-> (data_r == '0), "data byte on a frame event")
  `XCFD_ASSERT(a_read_no_header, (valid_r && evt_r == xcfd_pkg::EV_READ) |-> (fn_r == '0 && len_r == '0), "header fields on a read")
  `XCFD_ASSERT(a_hit_needs_read, (s1_valid && s1_res.rd_hit) |-> (s1_res.evt == xcfd_pkg::EV_READ), "store hit on a frame event")

endmodule

// ===== hw/rtl/xor_checksum_frame_decoder_unit.sv =====
// A result is registered first in the parser register, then in the output register,
// which loads when empty or when the sink takes. Throughput: one item per cycle, back to back,
// unless a stalled sink fills both result registers; bytes that cause no result leave nothing.
// Reset (rst_n, synchronous, active low): receiver waits for a start byte, checksum
// restarts at 0xFE, accepted length is zero, both result registers empty.
// The payload store is not cleared; reads are gated by the accepted length.
module xor_checksum_frame_decoder_unit #(
  parameter int MAX_PAYLOAD = xcfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  xcfd_in_if.sink     in_if,
  xcfd_out_if.source  out_if
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // parser -> output stage
  logic                        take;
  logic                        s1_valid;
  xcfd_pkg::res_t              s1_res;

  // payload store port
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [xcfd_pkg::BYTE_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [xcfd_pkg::BYTE_W-1:0] rd_data;

  // Stage 1: phase machine and checksum act on the item at the accepting edge;
  // the store read for a read item is launched at the same edge.
  xcfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_res   (s1_res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  // Payload store. Read data stays put until the next read, which only
  // happens once the held result has moved to the output register.
  xcfd_ram #(
    .WIDTH (xcfd_pkg::BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage 2: output register; decouples a stalled sink from the receiver.
  xcfd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_res   (s1_res),
    .rd_data  (rd_data),
    .take     (take),
    .out_if   (out_if)
  );

endmodule
